@@ hdl/tall_digit_glyph_plotter_top_assert.svh @@
// Assertion macros shared by the glyph plotter RTL.
`ifndef TALL_DIGIT_GLYPH_PLOTTER_TOP_ASSERT_SVH
`define TALL_DIGIT_GLYPH_PLOTTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset
`define TDGP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("glyph plotter check failed");
// Next-cycle implication
`define TDGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("glyph plotter check failed");
`else
`define TDGP_ASSERT_NOW(label, ante, cons)
`define TDGP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/tdgp_pkg.sv @@
// Shared constants, types and the digit font table of the glyph plotter.
package tdgp_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 12;
    localparam int WIDTH_W = 11;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 3;
    localparam int DIGIT_W = 4;

    // Default glyph scan size
    localparam int GLYPH_ROWS_DEF = 10;
    localparam int GLYPH_COLS_DEF = 5;

    // Font storage: ten digits, ten stored rows each
    localparam int ROM_DIGITS = 10;
    localparam int ROM_ROWS   = 10;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;

    // Pen advances and colon dot offsets above the baseline
    localparam logic [COORD_W-1:0] ADV_DIGIT  = 12'd6;
    localparam logic [COORD_W-1:0] ADV_COLON  = 12'd3;
    localparam logic [COORD_W-1:0] DOT_HI_OFF = 12'd8;
    localparam logic [COORD_W-1:0] DOT_LO_OFF = 12'd3;

    // Result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // Text state memory: one entry holding pen position and text start
    localparam int STATE_DEPTH = 1;
    localparam int STATE_W     = 2 * COORD_W;

    typedef logic [7:0] t_glyph_row;

    // Scanner control from the sequencer
    typedef struct packed {
        logic               start;
        logic               step;
        logic [DIGIT_W-1:0] digit;
    } t_scan_ctl;

    // Scanner status back to the sequencer
    typedef struct packed {
        logic             busy;
        logic             hit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_scan_sts;

    localparam t_glyph_row GLYPH_ROM [ROM_DIGITS][ROM_ROWS] = '{
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h04, 8'h0c, 8'h14, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0e},
        '{8'h0e, 8'h11, 8'h01, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h10, 8'h1f},
        '{8'h1e, 8'h01, 8'h01, 8'h01, 8'h0e, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1e},
        '{8'h02, 8'h06, 8'h0a, 8'h0a, 8'h12, 8'h12, 8'h1f, 8'h02, 8'h02, 8'h02},
        '{8'h1f, 8'h10, 8'h10, 8'h10, 8'h1e, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1e},
        '{8'h0e, 8'h10, 8'h10, 8'h10, 8'h1e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h1f, 8'h01, 8'h01, 8'h02, 8'h02, 8'h04, 8'h04, 8'h08, 8'h08, 8'h08},
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h01, 8'h01, 8'h01, 8'h0e}
    };

    // Look up one font row; rows past the stored ones are empty
    function automatic t_glyph_row glyph_row(input logic [DIGIT_W-1:0] digit,
                                             input logic [ROW_W-1:0] row);
        t_glyph_row bits;
        bits = '0;
        if ((int'(digit) < ROM_DIGITS) && (int'(row) < ROM_ROWS)) begin
            bits = GLYPH_ROM[digit][row];
        end
        return bits;
    endfunction

endpackage

@@ hdl/tdgp_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tdgp_ram
    import tdgp_pkg::*;
#(
    parameter int WIDTH = STATE_W,
    parameter int DEPTH = STATE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tdgp_scan.sv @@
// Glyph cell scanner: walks rows and columns of one digit, one cell per step.
module tdgp_scan
    import tdgp_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS = GLYPH_COLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    output t_scan_sts o_sts
);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLS - 1);

    logic               r_busy;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [DIGIT_W-1:0] r_digit;

    t_glyph_row       row_bits;
    logic [COL_W-1:0] bit_idx;
    logic             at_last;

    // Current cell: leftmost column sits in the highest used bit
    assign row_bits = glyph_row(r_digit, r_row);
    assign bit_idx  = COL_LAST - r_col;
    assign at_last  = (r_row == ROW_LAST) && (r_col == COL_LAST);

    // Advance the scan position; return to the top-left cell when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_ctl.step && r_busy) begin
            if (at_last) begin
                r_busy <= 1'b0;
                r_row  <= '0;
                r_col  <= '0;
            end else if (r_col == COL_LAST) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Hold the digit for the whole scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_digit <= i_ctl.digit;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.hit  = r_busy && row_bits[bit_idx];
    assign o_sts.last = at_last;
    assign o_sts.row  = r_row;
    assign o_sts.col  = r_col;

endmodule

@@ hdl/tall_digit_glyph_plotter_top.sv @@
// Top level of the tall digit glyph plotter: sequencer, text state memory, output register.
// Sequence: accept, state memory read in S_READ, then per character:
//   digit GLYPH_ROWS*GLYPH_COLS cells (one per cycle unless the output stalls, set bits give pixels) plus a marker,
//   colon two dots plus marker, other bytes the marker alone.
// Throughput: a new character is accepted only once the previous one has sent its marker;
//   paced by the one-cell-per-cycle glyph scan and by output stalls.
// Reset: synchronous, active low; clears the sequencer, scanner, output valid and the
//   text state valid bit, so pen position and text start read as zero until first written.
module tall_digit_glyph_plotter_top
    import tdgp_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS = GLYPH_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // char_code[7:0], pen_x[19:8], baseline[31:20]
    input  logic        i_s_tuser,   // first_of_text[0]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // px[11:0], py[23:12], text_width[34:24], zero[39:35]
    output logic        o_m_tuser,   // kind[0]
    output logic        o_m_tlast    // last_in_run
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_DOT1 = 6'b000100,
        S_DOT2 = 6'b001000,
        S_SCAN = 6'b010000,
        S_MARK = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Item registers
    logic [CHAR_W-1:0]  r_char;
    logic [COORD_W-1:0] r_pen_x;
    logic [COORD_W-1:0] r_base;
    logic               r_first;

    // Working text state
    logic [COORD_W-1:0] r_pen;
    logic [COORD_W-1:0] r_start;
    logic               r_state_vld;

    // Output register
    logic               r_out_valid;
    logic               r_out_kind;
    logic [COORD_W-1:0] r_out_px;
    logic [COORD_W-1:0] r_out_py;
    logic [WIDTH_W-1:0] r_out_width;
    logic               r_out_last;

    // Memory port signals
    logic               mem_re;
    logic               mem_we;
    logic [0:0]         mem_addr;
    logic [STATE_W-1:0] mem_wdata;
    logic [STATE_W-1:0] mem_rdata;

    t_scan_ctl scan_ctl;
    t_scan_sts scan_sts;

    logic               accept;
    logic               can_load;
    logic               is_digit;
    logic               is_colon;
    logic [COORD_W-1:0] rd_pen;
    logic [COORD_W-1:0] rd_start;
    logic [COORD_W-1:0] ld_pen;
    logic [COORD_W-1:0] ld_start;
    logic [COORD_W-1:0] n_pen;
    logic [COORD_W-1:0] diff;

    logic               load_out;
    logic               out_kind;
    logic [COORD_W-1:0] out_px;
    logic [COORD_W-1:0] out_py;
    logic [WIDTH_W-1:0] out_width;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign can_load   = !r_out_valid || i_m_tready;

    // Decode the held character
    assign is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign is_colon = (r_char == CH_COLON);

    // Text state as read back; an unwritten entry reads as zero
    assign rd_pen   = r_state_vld ? mem_rdata[COORD_W-1:0] : '0;
    assign rd_start = r_state_vld ? mem_rdata[STATE_W-1:COORD_W] : '0;
    assign ld_pen   = r_first ? r_pen_x : rd_pen;
    assign ld_start = r_first ? r_pen_x : rd_start;

    // Pen after this character and width since text start
    assign n_pen = r_pen + (is_colon ? ADV_COLON : ADV_DIGIT);
    assign diff  = n_pen - r_start;

    // Text state memory
    assign mem_addr  = '0;
    assign mem_re    = accept;
    assign mem_wdata = {r_start, n_pen};

    tdgp_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    tdgp_scan #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .GLYPH_COLS (GLYPH_COLS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_sts   (scan_sts)
    );

    // Sequence one character: read state, emit pixels, emit marker, write back
    always_comb begin
        n_state        = r_state;
        scan_ctl       = '0;
        scan_ctl.digit = DIGIT_W'(r_char - CH_ZERO);
        mem_we         = 1'b0;
        load_out       = 1'b0;
        out_kind       = KIND_PIXEL;
        out_px         = r_pen;
        out_py         = r_base;
        out_width      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (is_colon) begin
                    n_state = S_DOT1;
                end else if (is_digit) begin
                    n_state        = S_SCAN;
                    scan_ctl.start = 1'b1;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_DOT1: begin
                out_py = r_base - DOT_HI_OFF;
                if (can_load) begin
                    load_out = 1'b1;
                    n_state  = S_DOT2;
                end
            end
            S_DOT2: begin
                out_py = r_base - DOT_LO_OFF;
                if (can_load) begin
                    load_out = 1'b1;
                    n_state  = S_MARK;
                end
            end
            S_SCAN: begin
                out_px = r_pen + COORD_W'(scan_sts.col);
                out_py = r_base - COORD_W'(GLYPH_ROWS) + COORD_W'(scan_sts.row);
                if (can_load) begin
                    scan_ctl.step = 1'b1;
                    load_out      = scan_sts.hit;
                    if (scan_sts.last) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                out_kind  = KIND_MARKER;
                out_px    = '0;
                out_py    = '0;
                out_width = diff[WIDTH_W-1:0];
                if (can_load) begin
                    load_out = 1'b1;
                    mem_we   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_state_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_state_vld <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char  <= i_s_tdata[7:0];
            r_pen_x <= i_s_tdata[19:8];
            r_base  <= i_s_tdata[31:20];
            r_first <= i_s_tuser;
        end
    end

    // Load the working pen and text start once the state read returns
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_pen   <= ld_pen;
            r_start <= ld_start;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind  <= out_kind;
            r_out_px    <= out_px;
            r_out_py    <= out_py;
            r_out_width <= out_width;
            r_out_last  <= (out_kind == KIND_MARKER);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_width, r_out_py, r_out_px};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

`include "tall_digit_glyph_plotter_top_assert.svh"

    // Marker and end of run always travel together
    `TDGP_ASSERT_NOW(a_marker_last, o_m_tvalid, (o_m_tuser == o_m_tlast))
    // Pixel results carry no width
    `TDGP_ASSERT_NOW(a_pixel_no_width, o_m_tvalid && !o_m_tuser, (o_m_tdata[34:24] == '0))
    // State write-back and the next read never share a cycle
    `TDGP_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re)
    // Scan counters are back at the top-left cell whenever the sequencer is idle
    `TDGP_ASSERT_NOW(a_scan_parked, r_state == S_IDLE,
                     !scan_sts.busy && (scan_sts.row == '0) && (scan_sts.col == '0))
    // A digit read starts the scanner
    `TDGP_ASSERT_NEXT(a_scan_starts, (r_state == S_READ) && is_digit, scan_sts.busy)

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the tall digit glyph plotter: directed, stall, random and width-wrap tests.
`timescale 1ns / 1ps

module tb;
    import tdgp_pkg::*;

    localparam int ROWS         = GLYPH_ROWS_DEF;
    localparam int COLS         = GLYPH_COLS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * (ROWS * COLS + 3);
    localparam int RANDOM_ITEMS = 170;
    localparam int WRAP_ITEMS   = 50;

    // One plotted result as the block should present it
    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [WIDTH_W-1:0] span;
        logic               last;
    } t_plot;

    // Digit font for the predictor; column 0 sits in bit COLS-1 of each row
    localparam logic [7:0] DIGIT_FONT [10][10] = '{
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h04, 8'h0c, 8'h14, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0e},
        '{8'h0e, 8'h11, 8'h01, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h10, 8'h1f},
        '{8'h1e, 8'h01, 8'h01, 8'h01, 8'h0e, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1e},
        '{8'h02, 8'h06, 8'h0a, 8'h0a, 8'h12, 8'h12, 8'h1f, 8'h02, 8'h02, 8'h02},
        '{8'h1f, 8'h10, 8'h10, 8'h10, 8'h1e, 8'h01, 8'h01, 8'h01, 8'h01, 8'h1e},
        '{8'h0e, 8'h10, 8'h10, 8'h10, 8'h1e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h1f, 8'h01, 8'h01, 8'h02, 8'h02, 8'h04, 8'h04, 8'h08, 8'h08, 8'h08},
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e},
        '{8'h0e, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0f, 8'h01, 8'h01, 8'h01, 8'h0e}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;    // char_code[7:0], pen_x[19:8], baseline[31:20]
    logic        i_s_tuser  = 1'b0;  // first_of_text[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;          // px[11:0], py[23:12], text_width[34:24], zero[39:35]
    logic        o_m_tuser;          // kind[0]
    logic        o_m_tlast;

    t_plot              pending_plots[$];
    logic [COORD_W-1:0] model_pen    = '0;
    logic [COORD_W-1:0] model_origin = '0;
    int                 fail_count   = 0;
    int unsigned        cycle_count  = 0;
    int                 holdoff_left = 0;
    bit                 no_idle      = 1'b0;

    tall_digit_glyph_plotter_top #(
        .GLYPH_ROWS(ROWS),
        .GLYPH_COLS(COLS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abandon a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Any byte that is neither a digit nor a colon
    function automatic logic [CHAR_W-1:0] pick_blank();
        logic [CHAR_W-1:0] ch;
        do ch = CHAR_W'($urandom); while (ch >= CH_ZERO && ch <= CH_COLON);
        return ch;
    endfunction

    function automatic void push_plot(input logic kind, input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [WIDTH_W-1:0] span, input logic last);
        t_plot p;
        p.kind = kind;
        p.px   = x;
        p.py   = y;
        p.span = span;
        p.last = last;
        pending_plots.push_back(p);
    endfunction

    // Work out every result one character causes and advance the pen
    function automatic void plot_char(input logic [CHAR_W-1:0] ch,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] base, input logic first);
        logic [7:0]         bits;
        logic [COORD_W-1:0] advance;
        int                 digit;
        int                 row;
        int                 col;
        if (first) begin
            model_pen    = x;
            model_origin = x;
        end
        if (ch == CH_COLON) begin
            push_plot(KIND_PIXEL, model_pen, base - DOT_HI_OFF, '0, 1'b0);
            push_plot(KIND_PIXEL, model_pen, base - DOT_LO_OFF, '0, 1'b0);
            model_pen = model_pen + ADV_COLON;
        end else begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                digit = int'(ch - CH_ZERO);
                for (row = 0; row < ROWS; row++) begin
                    // rows past the stored font are blank
                    bits = (row < 10) ? DIGIT_FONT[digit][row] : 8'h00;
                    for (col = 0; col < COLS; col++) begin
                        if (bits[COLS-1-col]) begin
                            push_plot(KIND_PIXEL, model_pen + COORD_W'(col),
                                      base - COORD_W'(ROWS) + COORD_W'(row), '0, 1'b0);
                        end
                    end
                end
            end
            model_pen = model_pen + ADV_DIGIT;
        end
        // marker carries the advance since the text began, cut to 11 bits
        advance = model_pen - model_origin;
        push_plot(KIND_MARKER, '0, '0, advance[WIDTH_W-1:0], 1'b1);
    endfunction

    // Offer one character and record its results once the transfer happens
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] base, input logic first);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {base, x, ch};
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        plot_char(ch, x, base, first);
    endtask

    function automatic void compare_field(input string name, input logic [COORD_W-1:0] want,
                                          input logic [COORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Result sink: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                i_m_tready <= 1'b0;
                holdoff_left--;
            end else if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
                stall = no_idle ? 0 : pick_gap();
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_plot seen;
        t_plot want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.kind = o_m_tuser;
            seen.px   = o_m_tdata[11:0];
            seen.py   = o_m_tdata[23:12];
            seen.span = o_m_tdata[34:24];
            seen.last = o_m_tlast;
            if (pending_plots.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                fail_count++;
            end else begin
                want = pending_plots.pop_front();
                compare_field("kind", COORD_W'(want.kind), COORD_W'(seen.kind));
                compare_field("px", want.px, seen.px);
                compare_field("py", want.py, seen.py);
                compare_field("text_width", COORD_W'(want.span), COORD_W'(seen.span));
                compare_field("last_in_run", COORD_W'(want.last), COORD_W'(seen.last));
            end
        end
    end

    // Extremes of every field, each digit, colon and blank bytes
    task automatic test_directed();
        int k;
        // no text started yet: pen and origin sit at zero
        send_char(CH_ZERO + 8'd8, 12'h07B, 12'h014, 1'b0);
        send_char(8'h00, 12'hFFF, 12'h000, 1'b0);
        // every digit from the most negative pen, baselines at the extremes
        send_char(CH_ZERO, 12'h800, 12'h800, 1'b1);
        for (k = 1; k < 10; k++) begin
            send_char(CH_ZERO + CHAR_W'(k), 12'h000, (k % 2 == 1) ? 12'h7FF : 12'h000, 1'b0);
        end
        // colon dots wrapping below the most negative baseline
        send_char(CH_COLON, 12'h555, 12'h800, 1'b0);
        send_char(CH_COLON, 12'h7FF, 12'h7FF, 1'b1);
        send_char(8'hFF, 12'hAAA, 12'h005, 1'b0);
        // pen crossing the top of the coordinate range
        send_char(CH_NINE, 12'hFFE, 12'h005, 1'b1);
        send_char(CH_ZERO - 8'd1, 12'h123, 12'hFFF, 1'b0);
        send_char(CH_COLON + 8'd1, 12'hEDC, 12'h001, 1'b0);
        send_char(CH_ZERO + 8'd1, 12'h7FE, 12'h003, 1'b1);
        send_char(CH_COLON, 12'h000, 12'h008, 1'b0);
        send_char(CH_ZERO + 8'd4, 12'hFFF, 12'hFFF, 1'b0);
    endtask

    // Hold the result side off while characters keep coming
    task automatic test_output_stall();
        int k;
        holdoff_left = 400;
        no_idle      = 1'b1;
        for (k = 0; k < 6; k++) begin
            send_char(CH_ZERO + CHAR_W'(k + 3), 12'($urandom), 12'($urandom), k == 0);
        end
        no_idle = 1'b0;
    endtask

    // Texts of random length and content, with some broken starts
    task automatic test_random_texts();
        int                 sent;
        int                 len;
        int                 k;
        int                 roll;
        logic [COORD_W-1:0] base;
        logic [CHAR_W-1:0]  ch;
        logic               first;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // a stretch without idling on either side
            no_idle = (sent >= 100 && sent < 140);
            len     = $urandom_range(1, 10);
            base    = 12'($urandom);
            for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    ch = CH_ZERO + CHAR_W'($urandom_range(0, 9));
                end else if (roll < 75) begin
                    ch = CH_COLON;
                end else begin
                    ch = CHAR_W'($urandom);
                end
                if ($urandom_range(0, 9) == 0) base = 12'($urandom);
                if (k == 0) first = ($urandom_range(0, 9) != 0);
                else first = ($urandom_range(0, 19) == 0);
                send_char(ch, 12'($urandom), base, first);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // One long text started near the top of the range so the pen wraps under the width
    task automatic test_width_wrap();
        int                k;
        logic [CHAR_W-1:0] ch;
        for (k = 0; k < WRAP_ITEMS; k++) begin
            ch = ($urandom_range(0, 9) == 0) ? CH_COLON : pick_blank();
            send_char(ch, (k == 0) ? 12'hF40 : 12'($urandom), 12'($urandom), k == 0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_stall();
        test_random_texts();
        test_width_wrap();

        // drop the input and let every result drain
        i_s_tvalid <= 1'b0;
        while (pending_plots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ tall_digit_glyph_plotter_top.f @@
+incdir+hdl
hdl/tdgp_pkg.sv
hdl/tdgp_ram.sv
hdl/tdgp_scan.sv
hdl/tall_digit_glyph_plotter_top.sv
bench/tb.sv
